@@ sv/repeating_timer_table_macros.svh @@
// assertion macros for the repeating timer table
`ifndef REPEATING_TIMER_TABLE_MACROS_SVH
`define REPEATING_TIMER_TABLE_MACROS_SVH

`ifndef SYNTH
// check a property on every rising clock edge outside reset
`define RTT_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("repeating timer table assertion failed");
// check that a condition holds in the cycle after a trigger
`define RTT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("repeating timer table assertion failed");
`else
`define RTT_ASSERT(lbl, ck, rs, prop)
`define RTT_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif

`endif

@@ sv/rtt_pkg.sv @@
// types and constants of the repeating timer table
package rtt_pkg;

  // input item modes (s_tuser)
  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_ARM  = 2'd1;
  localparam logic [1:0] MODE_DEL  = 2'd2;

  // result kinds (m_tuser)
  localparam logic [1:0] KIND_ARM   = 2'd0;
  localparam logic [1:0] KIND_DEL   = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // field widths
  localparam int TIME_W   = 32;
  localparam int SLOT_W   = 4;
  localparam int PMS_W    = 20;
  localparam int PERIOD_W = 16;
  localparam int COUNT_W  = 17;
  // at most sixteen slots can be addressed, so at most sixteen fire
  localparam int FIRES_W  = 5;

  // divide by ten as multiply by ceil(2^23 / 10) and shift
  localparam int               RECIP_SHIFT = 23;
  localparam int               PROD_W      = 2 * PMS_W;
  localparam logic [PMS_W-1:0] RECIP       = 20'd838861;
  localparam logic [PMS_W-1:0] MIN_PMS     = 20'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM_MUL,
    ST_ARM_WR,
    ST_DEL,
    ST_SCAN,
    ST_SCAN_END,
    ST_FIRE
  } state_t;

endpackage

@@ sv/repeating_timer_table.sv @@
// repeating timer table: slot store, deadline scan and fire sequencer
`include "repeating_timer_table_macros.svh"

// A table of TIMER_SLOTS repeating timers driven by a stream of items. s_tuser
// picks the job: arm loads a slot with period_ms / 10, a repeat count
// (negative runs forever) and a deadline of current_time plus period, and is
// rejected for a zero count, a period_ms under 10 or a slot beyond the table;
// delete frees a slot; tick fires every active slot whose deadline is at or
// before current_time, earliest deadline first and lowest slot on a tie. Each
// fired slot gives one beat of kind fired, tlast marks the final beat of an
// item, and a tick that fires nothing gives one beat of its own kind. Arm
// passes through ST_ARM_MUL and ST_ARM_WR, delete through ST_DEL, and a tick
// runs a scan for every slot that it fires, or one scan if it fires none:
// every firing needs one full pass of the single deadline comparator over
// the table, one slot per cycle, through the registered read port of the
// deadline memory. Results leave through an output register; the block takes
// no new item until all beats of the current one are out of the sequencer.
module repeating_timer_table
  import rtt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] current_time, [35:32] slot, [55:36] period_ms, [72:56] repeat_count
  input  logic [79:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] fired_slot, [4] status
  output logic [7:0]  m_tdata,
  // [1:0] kind
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  localparam int IW    = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = IW + 1;

  // sequencer
  state_t state, state_next;

  // latched input item
  logic [TIME_W-1:0]         now_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [PMS_W-1:0]          pms_r;
  logic signed [COUNT_W-1:0] count_r;

  // slot store
  logic [TIMER_SLOTS-1:0]    slot_active;
  logic [TIME_W-1:0]         slot_deadline [TIMER_SLOTS];
  logic [PERIOD_W-1:0]       slot_period   [TIMER_SLOTS];
  logic [COUNT_W-1:0]        slot_remaining[TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0]    done;

  // registered read data
  logic [TIME_W-1:0]         dl_q;
  logic [PERIOD_W-1:0]       per_q;
  logic signed [COUNT_W-1:0] rem_q;

  // scan state
  logic [CNT_W-1:0]          cnt;
  logic                      pipe_vld;
  logic [IW-1:0]             pipe_idx;
  logic                      best_vld;
  logic [IW-1:0]             best_idx;
  logic [TIME_W-1:0]         best_dl;
  logic [FIRES_W-1:0]        elig_cnt;

  // arm datapath
  logic [PROD_W-1:0]         prod;
  logic [PERIOD_W-1:0]       arm_period;
  logic [IW+SLOT_W-1:0]      slot_ext;
  logic [IW-1:0]             slot_idx;
  logic                      slot_ok;
  logic                      reject;

  // shared deadline adder
  logic [PERIOD_W-1:0]       add_b;
  logic [TIME_W-1:0]         dl_sum;

  // candidate compare
  logic                      cand_ok;
  logic                      cand_better;

  // sequencer outputs
  logic                      out_free;
  logic                      accept;
  logic                      emit;
  logic [1:0]                res_kind;
  logic [SLOT_W-1:0]         res_slot;
  logic                      res_status;
  logic                      res_last;
  logic                      dl_we;
  logic                      per_we;
  logic                      rem_we;
  logic [IW-1:0]             wr_idx;
  logic [COUNT_W-1:0]        rem_wdata;
  logic                      act_set;
  logic                      act_clr;
  logic                      fire_last;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // slot field widened or cut to the table index
  assign slot_ext = {{IW{1'b0}}, slot_r};
  assign slot_idx = slot_ext[IW-1:0];
  assign slot_ok  = {1'b0, slot_ext} < (IW + SLOT_W + 1)'(TIMER_SLOTS);
  assign reject   = !slot_ok || (count_r == '0) || (pms_r < MIN_PMS);

  assign arm_period = prod[RECIP_SHIFT +: PERIOD_W];

  // one adder serves arm and re-arm after a firing
  assign add_b  = (state == ST_FIRE) ? per_q : arm_period;
  assign dl_sum = now_r + {{(TIME_W - PERIOD_W){1'b0}}, add_b};

  assign cand_ok     = slot_active[pipe_idx] && !done[pipe_idx] && (dl_q <= now_r);
  assign cand_better = !best_vld || (dl_q < best_dl);
  assign fire_last   = (elig_cnt == FIRES_W'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            MODE_TICK: state_next = ST_SCAN;
            MODE_ARM:  state_next = ST_ARM_MUL;
            MODE_DEL:  state_next = ST_DEL;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_ARM_MUL: state_next = ST_ARM_WR;
      ST_ARM_WR: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_DEL: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (cnt == CNT_W'(TIMER_SLOTS)) state_next = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        if (best_vld) begin
          state_next = ST_FIRE;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FIRE: begin
        if (out_free) state_next = fire_last ? ST_IDLE : ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: result beat and store writes
  always_comb begin
    emit       = 1'b0;
    res_kind   = KIND_ARM;
    res_slot   = slot_r;
    res_status = STATUS_OK;
    res_last   = 1'b1;
    dl_we      = 1'b0;
    per_we     = 1'b0;
    rem_we     = 1'b0;
    wr_idx     = slot_idx;
    rem_wdata  = count_r;
    act_set    = 1'b0;
    act_clr    = 1'b0;
    unique case (state)
      ST_ARM_WR: begin
        if (out_free) begin
          emit       = 1'b1;
          res_status = reject ? STATUS_REJECT : STATUS_OK;
          dl_we      = !reject;
          per_we     = !reject;
          rem_we     = !reject;
          act_set    = !reject;
        end
      end
      ST_DEL: begin
        if (out_free) begin
          emit     = 1'b1;
          res_kind = KIND_DEL;
          act_clr  = slot_ok;
        end
      end
      ST_SCAN_END: begin
        if (!best_vld && out_free) begin
          emit     = 1'b1;
          res_kind = KIND_NONE;
          res_slot = '0;
        end
      end
      ST_FIRE: begin
        wr_idx    = best_idx;
        rem_wdata = rem_q - COUNT_W'(1);
        if (out_free) begin
          emit     = 1'b1;
          res_kind = KIND_FIRED;
          res_slot = SLOT_W'(best_idx);
          res_last = fire_last;
          // count of one: slot is spent
          if (rem_q == COUNT_W'(1)) begin
            act_clr = 1'b1;
          end else begin
            dl_we  = 1'b1;
            rem_we = (rem_q > 0);
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      slot_active <= '0;
      done        <= '0;
      cnt         <= '0;
      pipe_vld    <= 1'b0;
      best_vld    <= 1'b0;
      elig_cnt    <= '0;
    end else begin
      state <= state_next;

      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (act_set) slot_active[wr_idx] <= 1'b1;
      if (act_clr) slot_active[wr_idx] <= 1'b0;

      // start of a tick, or start of the next firing round
      if ((accept && s_tuser == MODE_TICK) ||
          (state == ST_FIRE && out_free && !fire_last)) begin
        cnt      <= '0;
        best_vld <= 1'b0;
        elig_cnt <= '0;
      end else if (state == ST_SCAN && cnt != CNT_W'(TIMER_SLOTS)) begin
        cnt <= cnt + CNT_W'(1);
      end

      if (accept && s_tuser == MODE_TICK) done <= '0;
      if (state == ST_FIRE && out_free) done[best_idx] <= 1'b1;

      pipe_vld <= (state == ST_SCAN) && (cnt != CNT_W'(TIMER_SLOTS));

      if (pipe_vld && cand_ok) begin
        elig_cnt <= elig_cnt + FIRES_W'(1);
        if (cand_better) best_vld <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r   <= s_tdata[31:0];
      slot_r  <= s_tdata[35:32];
      pms_r   <= s_tdata[55:36];
      count_r <= s_tdata[72:56];
    end
    prod     <= {{PMS_W{1'b0}}, pms_r} * {{PMS_W{1'b0}}, RECIP};
    pipe_idx <= cnt[IW-1:0];
    if (pipe_vld && cand_ok && cand_better) begin
      best_idx <= pipe_idx;
      best_dl  <= dl_q;
    end
    if (emit) begin
      m_tuser <= res_kind;
      m_tdata <= {3'b000, res_status, res_slot};
      m_tlast <= res_last;
    end
  end

  // deadline memory: read by the scan, written by arm and re-arm
  always_ff @(posedge clk) begin
    if (dl_we) slot_deadline[wr_idx] <= dl_sum;
    dl_q <= slot_deadline[cnt[IW-1:0]];
  end

  // period memory
  always_ff @(posedge clk) begin
    if (per_we) slot_period[wr_idx] <= arm_period;
    per_q <= slot_period[best_idx];
  end

  // remaining count memory
  always_ff @(posedge clk) begin
    if (rem_we) slot_remaining[wr_idx] <= rem_wdata;
    rem_q <= slot_remaining[best_idx];
  end

  // a chosen slot was counted as eligible in its scan
  `RTT_ASSERT(a_best_counted, clk, rst, (state == ST_SCAN_END && best_vld) |-> (elig_cnt != '0))
  // the slot about to fire is live and has not fired on this tick
  `RTT_ASSERT(a_fire_live, clk, rst, (state == ST_FIRE) |-> (slot_active[best_idx] && !done[best_idx]))
  // a fired slot is marked so it cannot fire twice on one tick
  `RTT_ASSERT_NEXT(a_fire_marks, clk, rst, emit && state == ST_FIRE, done[$past(best_idx)])

endmodule

@@ verif/testbench.sv @@
// testbench for the repeating timer table: stream driver, result monitor and timer predictor
`timescale 1ns / 100ps

module testbench;
  import rtt_pkg::*;

  localparam int NUM_SLOTS   = 16;
  localparam int MIN_PMS_VAL = 10;
  localparam int RAND_ITEMS  = 220;
  localparam int TAIL_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;

  // one input beat as the driver sees it
  typedef struct packed {
    logic [1:0]         mode;
    logic [31:0]        now;
    logic [3:0]         slot;
    logic [19:0]        pms;
    logic signed [16:0] cnt;
    logic               drain;  // hold this beat until all results are back
  } timer_req_t;

  // one result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic       status;
    logic       last;
  } timer_evt_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = MODE_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  repeating_timer_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  timer_req_t pending_reqs[$];
  timer_evt_t awaited_events[$];
  int         fault_count = 0;

  // predictor copy of the slot table
  logic               slot_on   [NUM_SLOTS];
  logic [31:0]        slot_due  [NUM_SLOTS];
  logic [15:0]        slot_per  [NUM_SLOTS];
  logic signed [16:0] slot_left [NUM_SLOTS];

  // work out the result beats of one accepted item and update the table
  task automatic predict_timer_events(input timer_req_t r);
    timer_evt_t e;
    logic       fired_done [NUM_SLOTS];
    int         fired_list [NUM_SLOTS];
    int         n;
    int         best;
    logic       searching;
    if (r.mode == MODE_ARM) begin
      e.kind = KIND_ARM;
      e.slot = r.slot;
      e.last = 1'b1;
      if (r.cnt == 0 || r.pms < MIN_PMS_VAL) begin
        e.status = STATUS_REJECT;
      end else begin
        e.status = STATUS_OK;
        slot_on[r.slot]   = 1'b1;
        slot_per[r.slot]  = 16'(r.pms / MIN_PMS_VAL);
        slot_left[r.slot] = r.cnt;
        slot_due[r.slot]  = r.now + 32'(slot_per[r.slot]);
      end
      awaited_events.push_back(e);
    end else if (r.mode == MODE_DEL) begin
      slot_on[r.slot] = 1'b0;
      e.kind   = KIND_DEL;
      e.slot   = r.slot;
      e.status = STATUS_OK;
      e.last   = 1'b1;
      awaited_events.push_back(e);
    end else if (r.mode == MODE_TICK) begin
      for (int i = 0; i < NUM_SLOTS; i++) fired_done[i] = 1'b0;
      n = 0;
      searching = 1'b1;
      while (searching && n < NUM_SLOTS) begin
        best = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_on[i] && !fired_done[i] && slot_due[i] <= r.now) begin
            if (best < 0 || slot_due[i] < slot_due[best]) best = i;
          end
        end
        if (best < 0) begin
          searching = 1'b0;
        end else begin
          fired_done[best] = 1'b1;
          fired_list[n] = best;
          n++;
          if (slot_left[best] == 1) begin
            slot_on[best] = 1'b0;
          end else begin
            if (slot_left[best] > 0) slot_left[best] = slot_left[best] - 1;
            slot_due[best] = r.now + 32'(slot_per[best]);
          end
        end
      end
      if (n == 0) begin
        e.kind   = KIND_NONE;
        e.slot   = '0;
        e.status = STATUS_OK;
        e.last   = 1'b1;
        awaited_events.push_back(e);
      end else begin
        for (int k = 0; k < n; k++) begin
          e.kind   = KIND_FIRED;
          e.slot   = 4'(fired_list[k]);
          e.status = STATUS_OK;
          e.last   = (k == n - 1);
          awaited_events.push_back(e);
        end
      end
    end
    // the unused mode gives nothing
  endtask

  // driver: bursts of beats with random gaps between them
  int         burst_left = 1;
  int         gap_left = 0;
  timer_req_t bus_req;
  timer_req_t next_req;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_timer_events(bus_req);
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs[0];
          if (next_req.drain && awaited_events.size() != 0) begin
            s_tvalid <= 1'b0;
          end else begin
            bus_req = pending_reqs.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= bus_req.mode;
            s_tdata  <= {7'b0, bus_req.cnt, bus_req.pms, bus_req.slot, bus_req.now};
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
              burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 10);
              gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(0, 5);
            end
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: ready follows the bits of a 16-bit pattern that is redrawn each lap
  logic [15:0] rdy_pat = 16'hFFFF;
  logic [3:0]  rdy_pos = '0;
  logic [15:0] nxt_pat;
  timer_evt_t  got;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind   = m_tuser;
        got.slot   = m_tdata[3:0];
        got.status = m_tdata[4];
        got.last   = m_tlast;
        if (awaited_events.size() == 0) begin
          $display("%0t: beat with none expected, got kind %0d slot %0d status %0d last %0d",
                   $time, got.kind, got.slot, got.status, got.last);
          fault_count++;
        end else if (got != awaited_events[0]) begin
          $display("%0t: expected kind %0d slot %0d status %0d last %0d, got %0d %0d %0d %0d",
                   $time, awaited_events[0].kind, awaited_events[0].slot,
                   awaited_events[0].status, awaited_events[0].last,
                   got.kind, got.slot, got.status, got.last);
          fault_count++;
          void'(awaited_events.pop_front());
        end else begin
          void'(awaited_events.pop_front());
        end
      end
      nxt_pat = rdy_pat;
      if (rdy_pos == 4'd15) begin
        case ($urandom_range(0, 3))
          0: nxt_pat = 16'hFFFF;
          1: nxt_pat = 16'($urandom);
          2: nxt_pat = 16'h8000;  // long stall
          default: nxt_pat = 16'($urandom | $urandom);
        endcase
      end
      rdy_pat  <= nxt_pat;
      rdy_pos  <= rdy_pos + 4'd1;
      m_tready <= nxt_pat[rdy_pos + 4'd1];
    end
  end

  // stimulus
  int          item_count = 0;
  logic [31:0] now_t = '0;

  task automatic queue_req(input logic [1:0] mode, input logic [31:0] now,
                           input logic [3:0] slot, input logic [19:0] pms,
                           input logic signed [16:0] cnt, input logic drain);
    timer_req_t r;
    r.mode  = mode;
    r.now   = now;
    r.slot  = slot;
    r.pms   = pms;
    r.cnt   = cnt;
    r.drain = drain;
    pending_reqs.push_back(r);
    if (mode != 2'd3) item_count++;
  endtask

  function automatic logic [19:0] pick_pms();
    case ($urandom_range(0, 9))
      0: return 20'($urandom_range(0, 655359));
      1: return 20'd655359;
      2: return 20'($urandom_range(0, 9));
      default: return 20'($urandom_range(10, 300));
    endcase
  endfunction

  function automatic logic signed [16:0] pick_count();
    case ($urandom_range(0, 11))
      0: return -17'sd1;
      1: return 17'($urandom_range(0, 65535));
      2: return 17'sd0;
      default: return 17'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    int waited;
    int op;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_on[i]   = 1'b0;
      slot_due[i]  = '0;
      slot_per[i]  = '0;
      slot_left[i] = '0;
    end

    // directed part
    queue_req(MODE_TICK, 32'd0, 4'd0, 20'd0, 17'sd0, 1'b0);        // empty table
    queue_req(MODE_ARM, 32'd100, 4'd0, 20'd9, 17'sd1, 1'b0);       // short period
    queue_req(MODE_ARM, 32'd100, 4'd1, 20'd100, 17'sd0, 1'b0);     // zero count
    queue_req(MODE_ARM, 32'd100, 4'd2, 20'd10, 17'sd1, 1'b0);      // shortest period
    queue_req(MODE_ARM, 32'd100, 4'd3, 20'd655359, -17'sd1, 1'b0); // longest, forever
    queue_req(MODE_ARM, 32'd100, 4'd15, 20'd30, 17'sd65535, 1'b0); // top slot, top count
    queue_req(MODE_ARM, 32'd100, 4'd4, 20'd20, 17'sd2, 1'b0);
    queue_req(MODE_ARM, 32'd100, 4'd4, 20'd50, 17'sd3, 1'b0);      // re-arm replaces
    queue_req(MODE_TICK, 32'd100, 4'd0, 20'd0, 17'sd0, 1'b0);      // nothing due yet
    queue_req(MODE_TICK, 32'd103, 4'd0, 20'd0, 17'sd0, 1'b0);
    queue_req(MODE_DEL, 32'd103, 4'd15, 20'd0, 17'sd0, 1'b0);
    queue_req(MODE_DEL, 32'd103, 4'd7, 20'd0, 17'sd0, 1'b0);       // inactive slot
    queue_req(MODE_TICK, 32'd200, 4'd0, 20'd0, 17'sd0, 1'b0);
    queue_req(2'd3, 32'hFFFF_FFFF, 4'd15, 20'd655359, -17'sd1, 1'b0); // unused mode
    queue_req(MODE_ARM, 32'd300, 4'd5, 20'd40, -17'sd1, 1'b0);     // equal deadlines
    queue_req(MODE_ARM, 32'd300, 4'd6, 20'd40, -17'sd1, 1'b0);
    queue_req(MODE_ARM, 32'd300, 4'd7, 20'd40, -17'sd1, 1'b0);
    queue_req(MODE_TICK, 32'd304, 4'd0, 20'd0, 17'sd0, 1'b0);
    queue_req(MODE_ARM, 32'hFFFF_FFFA, 4'd8, 20'd100, 17'sd1, 1'b0); // deadline wraps
    queue_req(MODE_TICK, 32'hFFFF_FFFF, 4'd0, 20'd0, 17'sd0, 1'b0);
    queue_req(MODE_TICK, 32'd0, 4'd0, 20'd0, 17'sd0, 1'b0);
    queue_req(MODE_DEL, 32'd0, 4'd3, 20'd0, 17'sd0, 1'b1);         // after a full drain
    now_t = 32'd1000;

    // random part
    while (item_count < RAND_ITEMS) begin
      op = $urandom_range(0, 9);
      if (op <= 5) begin
        // ordinary traffic with time moving forward
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:
              queue_req(MODE_ARM, now_t, 4'($urandom), pick_pms(), pick_count(), 1'b0);
            8, 9, 10:
              queue_req(MODE_DEL, now_t, 4'($urandom), 20'($urandom), 17'($urandom),
                        1'b0);
            default: begin
              now_t = now_t + $urandom_range(0, 25);
              queue_req(MODE_TICK, now_t, 4'($urandom), 20'($urandom), 17'($urandom),
                        1'b0);
            end
          endcase
        end
      end else if (op == 6) begin
        // fill the table, then let everything expire at once
        for (int i = 0; i < NUM_SLOTS; i++) begin
          queue_req(MODE_ARM, now_t, 4'(i), 20'($urandom_range(10, 200)),
                    ($urandom_range(0, 1) != 0) ? -17'sd1 : 17'($urandom_range(1, 3)),
                    1'b0);
        end
        now_t = now_t + 32'd100;
        queue_req(MODE_TICK, now_t, 4'd0, 20'd0, 17'sd0, 1'b0);
        now_t = now_t + $urandom_range(0, 30);
        queue_req(MODE_TICK, now_t, 4'd0, 20'd0, 17'sd0, 1'b1);
      end else begin
        // noise: any mode, any time, any values
        op = $urandom_range(0, 3);
        if (op == MODE_TICK) now_t = $urandom;
        queue_req(2'(op), (op == MODE_TICK) ? now_t : $urandom, 4'($urandom),
                  20'($urandom_range(0, 655359)), pick_count(), 1'b0);
      end
      if ($urandom_range(0, 39) == 0) begin
        now_t = now_t + 32'd5;
        queue_req(MODE_TICK, now_t, 4'd0, 20'd0, 17'sd0, 1'b1);
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid) @(posedge clk);
    waited = 0;
    while (awaited_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_events.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, awaited_events.size());
      fault_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/rtt_pkg.sv
sv/repeating_timer_table.sv
verif/testbench.sv
